@@ sv/nsc_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
package nsc_pkg;

  localparam int CFG_INDEX_W = 4;

  localparam logic [CFG_INDEX_W-1:0] CFG_MAX_LEN = 4'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_TIMEOUT = 4'd1;

  localparam logic [7:0]  MAX_LEN_RESET = 8'd255;
  localparam logic [15:0] TIMEOUT_RESET = 16'd500;

  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;

  localparam logic [2:0] STAR_TAIL_LEN = 3'd4;
  localparam logic [2:0] STAR_CNT_MAX  = 3'd7;
  localparam logic [2:0] HEX_DIGITS    = 3'd2;

  typedef enum logic [0:0] {
    KIND_BYTE = 1'b0,
    KIND_TICK = 1'b1
  } kind_t;

  typedef enum logic [2:0] {
    ST_VALID    = 3'd0,
    ST_MISMATCH = 3'd1,
    ST_FORMAT   = 3'd2,
    ST_OVERFLOW = 3'd3,
    ST_TIMEOUT  = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    PH_HUNT = 3'b001,
    PH_BODY = 3'b010,
    PH_TAIL = 3'b100
  } phase_t;

  typedef struct packed {
    phase_t     phase;
    logic [7:0] running_xor;
    logic [7:0] char_count;
    logic [2:0] after_star_count;
    logic [7:0] parsed_sum;
    logic       digits_ok;
    logic       last_was_cr;
  } sent_state_t;

  localparam sent_state_t SENT_RESET = '{
    phase:            PH_HUNT,
    running_xor:      8'd0,
    char_count:       8'd0,
    after_star_count: 3'd0,
    parsed_sum:       8'd0,
    digits_ok:        1'b1,
    last_was_cr:      1'b0
  };

  typedef struct packed {
    status_t    status;
    logic [7:0] sentence_length;
    logic [7:0] computed_checksum;
    logic [7:0] received_checksum;
  } result_t;

  typedef struct packed {
    logic [7:0]  max_sentence_len;
    logic [15:0] timeout_ticks;
  } cfg_t;

  // {invalid, nibble}
  function automatic logic [4:0] hex_nibble(input logic [7:0] c);
    logic [4:0] r;
    r = 5'h10;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b0, 4'(c - 8'h30)};
    end else if (c >= 8'h41 && c <= 8'h46) begin
      r = {1'b0, 4'(c - 8'h37)};
    end else if (c >= 8'h61 && c <= 8'h66) begin
      r = {1'b0, 4'(c - 8'h57)};
    end
    return r;
  endfunction

endpackage
`default_nettype wire

@@ sv/nsc_item_if.sv @@
`timescale 1ns / 1ps
`default_nettype none
interface nsc_item_if;
  logic       valid;
  logic       ready;
  logic [0:0] item_kind;
  logic [7:0] rx_byte;

  modport source (output valid, output item_kind, output rx_byte, input ready);
  modport sink (input valid, input item_kind, input rx_byte, output ready);
endinterface
`default_nettype wire

@@ sv/nsc_result_if.sv @@
`timescale 1ns / 1ps
`default_nettype none
interface nsc_result_if;
  logic       valid;
  logic       ready;
  logic [2:0] status;
  logic [7:0] sentence_length;
  logic [7:0] computed_checksum;
  logic [7:0] received_checksum;

  modport source (output valid, output status, output sentence_length,
                  output computed_checksum, output received_checksum, input ready);
  modport sink (input valid, input status, input sentence_length,
                input computed_checksum, input received_checksum, output ready);
endinterface
`default_nettype wire

@@ sv/nsc_cfg_if.sv @@
`timescale 1ns / 1ps
`default_nettype none
interface nsc_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [nsc_pkg::CFG_INDEX_W-1:0] index;
  logic [15:0]                     data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

@@ sv/nsc_cfg_regs.sv @@
`timescale 1ns / 1ps
`default_nettype none
module nsc_cfg_regs (
  input  wire           clk,
  input  wire           rst,
  nsc_cfg_if.sink       cfg,
  output nsc_pkg::cfg_t regs
);

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.max_sentence_len <= nsc_pkg::MAX_LEN_RESET;
      regs.timeout_ticks    <= nsc_pkg::TIMEOUT_RESET;
    end else if (cfg.valid) begin
      if (cfg.index == nsc_pkg::CFG_MAX_LEN) begin
        regs.max_sentence_len <= cfg.data[7:0];
      end else if (cfg.index == nsc_pkg::CFG_TIMEOUT) begin
        regs.timeout_ticks <= cfg.data;
      end
    end
  end

endmodule
`default_nettype wire

@@ sv/nsc_step.sv @@
`timescale 1ns / 1ps
`default_nettype none
module nsc_step #(
  parameter int TICK_BITS = 16
) (
  input  nsc_pkg::sent_state_t state,
  input  logic [TICK_BITS-1:0] tick_count,
  input  nsc_pkg::kind_t       kind,
  input  logic [7:0]           rx_byte,
  input  nsc_pkg::cfg_t        cfg,
  output nsc_pkg::sent_state_t state_next,
  output logic [TICK_BITS-1:0] tick_next,
  output logic                 emit,
  output nsc_pkg::result_t     result
);

  localparam int LW = (TICK_BITS > 16) ? TICK_BITS : 16;
  localparam logic [TICK_BITS-1:0] TICK_MAX = {TICK_BITS{1'b1}};

  logic [LW-1:0]        limit;
  logic [TICK_BITS-1:0] tick_inc;
  logic [4:0]           hex;

  always_comb begin
    limit = (cfg.timeout_ticks == 16'd0) ? LW'(1) : LW'(cfg.timeout_ticks);
    if (limit > LW'(TICK_MAX)) begin
      limit = LW'(TICK_MAX);
    end
    tick_inc = (tick_count == TICK_MAX) ? tick_count : tick_count + 1'b1;
    hex      = nsc_pkg::hex_nibble(rx_byte);
  end

  always_comb begin
    state_next = state;
    tick_next  = tick_count;
    emit       = 1'b0;
    result     = '0;

    if (kind == nsc_pkg::KIND_TICK) begin
      tick_next = tick_inc;
      if (LW'(tick_inc) >= limit) begin
        if (state.phase == nsc_pkg::PH_BODY || state.phase == nsc_pkg::PH_TAIL) begin
          emit                     = 1'b1;
          result.status            = nsc_pkg::ST_TIMEOUT;
          result.sentence_length   = state.char_count;
          result.computed_checksum = state.running_xor;
        end else begin
          tick_next = '0;
        end
      end
    end else begin
      unique case (state.phase)
        nsc_pkg::PH_BODY, nsc_pkg::PH_TAIL: begin
          if (state.phase == nsc_pkg::PH_BODY) begin
            if (rx_byte == nsc_pkg::CH_STAR) begin
              state_next.phase = nsc_pkg::PH_TAIL;
            end else begin
              state_next.running_xor = state.running_xor ^ rx_byte;
            end
          end else begin
            if (state.after_star_count < nsc_pkg::HEX_DIGITS) begin
              if (hex[4]) begin
                state_next.digits_ok = 1'b0;
              end else begin
                state_next.parsed_sum = {state.parsed_sum[3:0], hex[3:0]};
              end
            end
            if (state.after_star_count < nsc_pkg::STAR_CNT_MAX) begin
              state_next.after_star_count = state.after_star_count + 3'd1;
            end
          end

          if (state.char_count > 8'd1 && rx_byte == nsc_pkg::CH_LF && state.last_was_cr) begin
            emit                     = 1'b1;
            result.sentence_length   = state.char_count + 8'd1;
            result.computed_checksum = state_next.running_xor;
            if (state_next.phase == nsc_pkg::PH_TAIL &&
                state_next.after_star_count == nsc_pkg::STAR_TAIL_LEN &&
                state_next.digits_ok) begin
              result.status = (state_next.parsed_sum == state_next.running_xor) ?
                              nsc_pkg::ST_VALID : nsc_pkg::ST_MISMATCH;
              result.received_checksum = state_next.parsed_sum;
            end else begin
              result.status = nsc_pkg::ST_FORMAT;
            end
          end else begin
            state_next.last_was_cr = (rx_byte == nsc_pkg::CH_CR);
            state_next.char_count  = state.char_count + 8'd1;
            if (state_next.char_count >= cfg.max_sentence_len) begin
              emit                     = 1'b1;
              result.status            = nsc_pkg::ST_OVERFLOW;
              result.sentence_length   = state_next.char_count;
              result.computed_checksum = state_next.running_xor;
            end
          end
        end
        default: begin
          if (rx_byte == nsc_pkg::CH_DOLLAR) begin
            state_next            = nsc_pkg::SENT_RESET;
            state_next.phase      = nsc_pkg::PH_BODY;
            state_next.char_count = 8'd1;
            if (8'd1 >= cfg.max_sentence_len) begin
              emit                   = 1'b1;
              result.status          = nsc_pkg::ST_OVERFLOW;
              result.sentence_length = 8'd1;
            end
          end
        end
      endcase
    end

    if (emit) begin
      state_next = nsc_pkg::SENT_RESET;
      tick_next  = '0;
    end
  end

endmodule
`default_nettype wire

@@ sv/nmea_sentence_checker_core.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Channel  Dir  Payload                                          Notes
// item     in   item_kind, rx_byte                               kind 0 byte, 1 tick
// result   out  status, sentence_length, computed/received sum   at most one per item
// cfg      in   index, data                                      always ready
//
// One item per cycle sustained while the result is not stalled; a result is registered
// (the transfer loads the input register, a later advance the result register).
// rst is synchronous: config returns to 255 / 500, framing state to hunting.
// A stalled result holds the result register; the input register keeps filling
// until it too is held, then item.ready drops.
module nmea_sentence_checker_core #(
  parameter int TICK_BITS = 16
) (
  input wire           clk,
  input wire           rst,
  nsc_item_if.sink     item,
  nsc_result_if.source result,
  nsc_cfg_if.sink      cfg
);

  nsc_pkg::cfg_t        cfg_regs;
  nsc_pkg::sent_state_t state;
  nsc_pkg::sent_state_t state_next;
  logic [TICK_BITS-1:0] tick_count;
  logic [TICK_BITS-1:0] tick_next;
  logic                 emit;
  nsc_pkg::result_t     res_next;
  nsc_pkg::result_t     res;

  logic           in_valid;
  nsc_pkg::kind_t in_kind;
  logic [7:0]     in_byte;
  logic           advance;

  nsc_cfg_regs u_cfg (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .regs (cfg_regs)
  );

  nsc_step #(
    .TICK_BITS (TICK_BITS)
  ) u_step (
    .state      (state),
    .tick_count (tick_count),
    .kind       (in_kind),
    .rx_byte    (in_byte),
    .cfg        (cfg_regs),
    .state_next (state_next),
    .tick_next  (tick_next),
    .emit       (emit),
    .result     (res_next)
  );

  assign advance    = in_valid && (!result.valid || result.ready);
  assign item.ready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (item.ready) begin
      in_valid <= item.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item.valid && item.ready) begin
      in_kind <= nsc_pkg::kind_t'(item.item_kind);
      in_byte <= item.rx_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= nsc_pkg::SENT_RESET;
      tick_count   <= '0;
      result.valid <= 1'b0;
    end else if (advance) begin
      state        <= state_next;
      tick_count   <= tick_next;
      result.valid <= emit;
    end else if (result.ready) begin
      result.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res <= res_next;
    end
  end

  assign result.status            = res.status;
  assign result.sentence_length   = res.sentence_length;
  assign result.computed_checksum = res.computed_checksum;
  assign result.received_checksum = res.received_checksum;

endmodule
`default_nettype wire
